// File: design/tse_pkg.sv
// Shared types and codes for the TLS SNI host name extractor.
package tse_pkg;

  localparam int unsigned CntW = 17;
  localparam logic [CntW-1:0] CntMax = '1;

  localparam logic [3:0] PH_WAIT  = 4'd0;
  localparam logic [3:0] PH_PRE   = 4'd1;
  localparam logic [3:0] PH_TOTAL = 4'd2;
  localparam logic [3:0] PH_HDR   = 4'd3;
  localparam logic [3:0] PH_BODY  = 4'd4;
  localparam logic [3:0] PH_LIST  = 4'd5;
  localparam logic [3:0] PH_TYPE  = 4'd6;
  localparam logic [3:0] PH_NLEN  = 4'd7;
  localparam logic [3:0] PH_NAME  = 4'd8;
  localparam logic [3:0] PH_DONE  = 4'd9;
  localparam logic [3:0] PH_TRAIL = 4'd10;

  localparam logic [1:0] ST_NAME      = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_NO_SNI    = 2'd2;
  localparam logic [1:0] ST_MALFORMED = 2'd3;

  localparam logic [15:0] SniExtId     = 16'h0000;
  localparam logic [7:0]  HostNameType = 8'h00;

  typedef struct packed {
    logic [3:0]      phase;
    logic [15:0]     ext_total;
    logic [CntW-1:0] ext_consumed;
    logic [2:0]      hdr_cnt;
    logic [15:0]     ext_id;
    logic [15:0]     skip;
    logic [15:0]     name_rem;
  } parse_state_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] name_byte;
    logic       name_last;
    logic [1:0] status;
  } result_t;

endpackage

// File: design/tse_step.sv
// Per-byte parser step: next parse state and optional result for one byte.
module tse_step
  import tse_pkg::*;
(
  input  parse_state_t state_i,
  input  logic [7:0]   data_byte_i,
  input  logic [15:0]  start_offset_i,
  input  logic         end_of_block_i,
  output parse_state_t state_o,
  output result_t      result_o
);

  parse_state_t s;
  result_t      r;

  always_comb begin
    s = state_i;
    r = '0;

    if (s.phase == PH_WAIT) begin
      s = '0;
      s.skip = start_offset_i;
      s.phase = PH_PRE;
    end
    if (s.phase == PH_PRE && s.skip == 16'd0) begin
      s.phase = PH_TOTAL;
      s.hdr_cnt = '0;
    end
    if (s.phase >= PH_HDR && s.phase != PH_DONE && s.ext_consumed != CntMax) begin
      s.ext_consumed = s.ext_consumed + CntW'(1);
    end

    unique case (s.phase)
      PH_PRE: begin
        s.skip = s.skip - 16'd1;
      end
      PH_TOTAL: begin
        s.ext_total = {s.ext_total[7:0], data_byte_i};
        s.hdr_cnt = s.hdr_cnt + 3'd1;
        if (s.hdr_cnt >= 3'd2) begin
          s.hdr_cnt = '0;
          s.phase = (s.ext_consumed < {1'b0, s.ext_total}) ? PH_HDR : PH_TRAIL;
        end
      end
      PH_HDR: begin
        if (s.hdr_cnt < 3'd2) begin
          s.ext_id = {s.ext_id[7:0], data_byte_i};
        end else begin
          s.skip = {s.skip[7:0], data_byte_i};
        end
        s.hdr_cnt = s.hdr_cnt + 3'd1;
        if (s.hdr_cnt >= 3'd4) begin
          s.hdr_cnt = '0;
          if (s.ext_id == SniExtId) begin
            s.phase = PH_LIST;
          end else if (s.skip == 16'd0) begin
            s.phase = (s.ext_consumed < {1'b0, s.ext_total}) ? PH_HDR : PH_TRAIL;
          end else begin
            s.phase = PH_BODY;
          end
        end
      end
      PH_BODY: begin
        s.skip = s.skip - 16'd1;
        if (s.skip == 16'd0) begin
          s.hdr_cnt = '0;
          s.phase = (s.ext_consumed < {1'b0, s.ext_total}) ? PH_HDR : PH_TRAIL;
        end
      end
      PH_LIST: begin
        s.hdr_cnt = s.hdr_cnt + 3'd1;
        if (s.hdr_cnt >= 3'd2) begin
          s.hdr_cnt = '0;
          s.phase = PH_TYPE;
        end
      end
      PH_TYPE: begin
        if (data_byte_i != HostNameType) begin
          r = '{valid: 1'b1, name_byte: 8'd0, name_last: 1'b1, status: ST_MALFORMED};
          s.phase = PH_DONE;
        end else begin
          s.name_rem = '0;
          s.hdr_cnt = '0;
          s.phase = PH_NLEN;
        end
      end
      PH_NLEN: begin
        s.name_rem = {s.name_rem[7:0], data_byte_i};
        s.hdr_cnt = s.hdr_cnt + 3'd1;
        if (s.hdr_cnt >= 3'd2) begin
          s.hdr_cnt = '0;
          if (s.name_rem == 16'd0) begin
            r = '{valid: 1'b1, name_byte: 8'd0, name_last: 1'b1, status: ST_EMPTY};
            s.phase = PH_DONE;
          end else begin
            s.phase = PH_NAME;
          end
        end
      end
      PH_NAME: begin
        s.name_rem = s.name_rem - 16'd1;
        if (s.name_rem == 16'd0) begin
          r = '{valid: 1'b1, name_byte: data_byte_i, name_last: 1'b1, status: ST_NAME};
          s.phase = PH_DONE;
        end else if (end_of_block_i) begin
          r = '{valid: 1'b1, name_byte: 8'd0, name_last: 1'b1, status: ST_MALFORMED};
          s.phase = PH_DONE;
        end else begin
          r = '{valid: 1'b1, name_byte: data_byte_i, name_last: 1'b0, status: ST_NAME};
        end
      end
      default: begin
      end
    endcase

    if (end_of_block_i) begin
      if (s.phase != PH_DONE) begin
        r.valid = 1'b1;
        r.name_byte = 8'd0;
        r.name_last = 1'b1;
        r.status = (s.phase == PH_TRAIL && s.ext_consumed == {1'b0, s.ext_total}) ?
                   ST_NO_SNI : ST_MALFORMED;
      end
      s.phase = PH_WAIT;
    end
  end

  assign state_o  = s;
  assign result_o = r;

endmodule

// File: design/tls_sni_hostname_extractor.sv
// Top level of the TLS SNI host name extractor: input register, parser, result register.
//
// Input stream: one message byte per beat. s_axis_tdata carries the byte and the
// extensions offset (sampled on the first beat of a block); s_axis_tlast marks the
// last byte of the block.
// Output stream: at most one result per input beat. m_axis_tdata is a host name
// byte, m_axis_tuser the status (name byte, empty name, no SNI, malformed) and
// m_axis_tlast the final result of the block.
// Each input beat passes the input register, then the parser step, then the result
// register; a result is held back further only while the output is stalled.
// Throughput: one byte per cycle while the output is not stalled; the parser step
// between the two registers is combinational.
// Reset clears both registers' valid flags and the parser state; the parser then
// waits for the first byte of a block.
// While the receiver stalls, the result holds; one more byte waits in the input
// register and s_axis_tready drops until the result is taken.
module tls_sni_hostname_extractor
  import tse_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // [7:0] data_byte, [23:8] start_offset
  input  logic        s_axis_tlast,  // end_of_block
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [7:0] name_byte
  output logic [1:0]  m_axis_tuser,  // [1:0] status
  output logic        m_axis_tlast   // name_last
);

  logic         in_valid_q;
  logic [7:0]   in_byte_q;
  logic [15:0]  in_offset_q;
  logic         in_eob_q;
  parse_state_t state_q, state_d;
  result_t      result_d;
  logic         out_valid_q;
  logic [7:0]   out_byte_q;
  logic         out_last_q;
  logic [1:0]   out_status_q;
  logic         out_free;
  logic         advance;

  assign out_free      = !out_valid_q || m_axis_tready;
  assign advance       = in_valid_q && out_free;
  assign s_axis_tready = !in_valid_q || advance;

  tse_step u_step (
    .state_i        (state_q),
    .data_byte_i    (in_byte_q),
    .start_offset_i (in_offset_q),
    .end_of_block_i (in_eob_q),
    .state_o        (state_d),
    .result_o       (result_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      state_q     <= '0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        state_q     <= state_d;
        out_valid_q <= result_d.valid;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q   <= s_axis_tdata[7:0];
      in_offset_q <= s_axis_tdata[23:8];
      in_eob_q    <= s_axis_tlast;
    end
    if (advance && result_d.valid) begin
      out_byte_q   <= result_d.name_byte;
      out_last_q   <= result_d.name_last;
      out_status_q <= result_d.status;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_status_q;

endmodule

// File: design/tse_checker.sv
// Port-level checks for the TLS SNI host name extractor, bound to the top level.
module tse_checker
  import tse_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
    $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result beat changed while stalled");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != ST_NAME |-> m_axis_tlast)
    else $error("status beat without last");

  a_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != ST_NAME |-> m_axis_tdata == 8'd0)
    else $error("status beat with nonzero data");

  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("input stalled while output is free");

endmodule

bind tls_sni_hostname_extractor tse_checker u_tse_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// File: tb/tls_sni_hostname_extractor_tb.sv
// Self-checking stream testbench for the TLS SNI host name extractor.
`timescale 1ns / 100ps

module tls_sni_hostname_extractor_tb;
  import tse_pkg::*;

  localparam int unsigned RandBeats   = 1225;
  localparam int unsigned IdleLimit   = 2000;
  localparam int unsigned DrainCycles = 8;

  typedef struct packed {
    logic [7:0]  data;
    logic [15:0] off;
    logic        eob;
  } beat_t;

  typedef struct packed {
    beat_t   bt;
    result_t want;
  } row_t;

  localparam result_t NoCheck = '0;

  // rows with want.valid set carry a hand-written expectation
  localparam row_t DirRows [25] = '{
    '{'{8'hFF, 16'h0000, 1'b1}, '{1'b1, 8'h00, 1'b1, ST_MALFORMED}},
    '{'{8'h00, 16'hFFFF, 1'b1}, '{1'b1, 8'h00, 1'b1, ST_MALFORMED}},
    '{'{8'h00, 16'h0000, 1'b0}, NoCheck},
    '{'{8'h00, 16'hFFFF, 1'b1}, '{1'b1, 8'h00, 1'b1, ST_NO_SNI}},
    // wrong entry type
    '{'{8'h00, 16'h0000, 1'b0}, NoCheck},
    '{'{8'h01, 16'h5A5A, 1'b0}, NoCheck},
    '{'{8'h00, 16'hA5A5, 1'b0}, NoCheck},
    '{'{8'h00, 16'h0000, 1'b0}, NoCheck},
    '{'{8'h00, 16'hFFFF, 1'b0}, NoCheck},
    '{'{8'h00, 16'h0000, 1'b0}, NoCheck},
    '{'{8'h00, 16'h0000, 1'b0}, NoCheck},
    '{'{8'h00, 16'h0000, 1'b0}, NoCheck},
    '{'{8'hFF, 16'h0000, 1'b1}, '{1'b1, 8'h00, 1'b1, ST_MALFORMED}},
    // one-byte host name
    '{'{8'h00, 16'h0000, 1'b0}, NoCheck},
    '{'{8'h0A, 16'h1234, 1'b0}, NoCheck},
    '{'{8'h00, 16'h0000, 1'b0}, NoCheck},
    '{'{8'h00, 16'h0000, 1'b0}, NoCheck},
    '{'{8'h00, 16'h0000, 1'b0}, NoCheck},
    '{'{8'h06, 16'h0000, 1'b0}, NoCheck},
    '{'{8'h00, 16'h0000, 1'b0}, NoCheck},
    '{'{8'h04, 16'h0000, 1'b0}, NoCheck},
    '{'{8'h00, 16'h0000, 1'b0}, NoCheck},
    '{'{8'h00, 16'h0000, 1'b0}, NoCheck},
    '{'{8'h01, 16'h0000, 1'b0}, NoCheck},
    '{'{8'h7A, 16'hFFFF, 1'b1}, '{1'b1, 8'h7A, 1'b1, ST_NAME}}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;  // [7:0] data_byte, [23:8] start_offset
  logic        s_axis_tlast = 1'b0;  // end_of_block
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;  // [7:0] name_byte
  logic [1:0]  m_axis_tuser;  // [1:0] status
  logic        m_axis_tlast;  // name_last

  // predictor state
  logic [3:0]      ph = PH_WAIT;
  logic [15:0]     ext_len_total = '0;
  logic [CntW-1:0] ext_seen = '0;
  logic [2:0]      fld_cnt = '0;
  logic [15:0]     ext_code = '0;
  logic [15:0]     skip_left = '0;
  logic [15:0]     host_left = '0;
  logic            blk_finished = 1'b0;

  result_t     result_q[$];
  beat_t       blk_q[$];
  logic [7:0]  ext_q[$];
  int unsigned mismatch_cnt = 0;
  int unsigned idle_cnt = 0;
  int unsigned stall_left = 0;
  bit          steady = 1'b0;

  tls_sni_hostname_extractor i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk_i = ~clk_i;

  function automatic void ext_boundary();
    fld_cnt = '0;
    ph = (ext_seen < {1'b0, ext_len_total}) ? PH_HDR : PH_TRAIL;
  endfunction

  function automatic result_t sni_predict(input logic [7:0] b, input logic [15:0] off,
                                          input logic eob);
    result_t r;
    r = '0;
    if (ph == PH_WAIT) begin
      ext_len_total = '0;
      ext_seen = '0;
      fld_cnt = '0;
      ext_code = '0;
      host_left = '0;
      blk_finished = 1'b0;
      skip_left = off;
      ph = PH_PRE;
    end
    if (ph == PH_PRE && skip_left == '0) begin
      ph = PH_TOTAL;
      fld_cnt = '0;
    end
    if (ph >= PH_HDR && ph != PH_DONE && ext_seen != CntMax) ext_seen++;
    case (ph)
      PH_PRE: skip_left--;
      PH_TOTAL: begin
        ext_len_total = {ext_len_total[7:0], b};
        fld_cnt++;
        if (fld_cnt >= 3'd2) ext_boundary();
      end
      PH_HDR: begin
        if (fld_cnt < 3'd2) ext_code = {ext_code[7:0], b};
        else skip_left = {skip_left[7:0], b};
        fld_cnt++;
        if (fld_cnt >= 3'd4) begin
          fld_cnt = '0;
          if (ext_code == SniExtId) ph = PH_LIST;
          else if (skip_left == '0) ext_boundary();
          else ph = PH_BODY;
        end
      end
      PH_BODY: begin
        skip_left--;
        if (skip_left == '0) ext_boundary();
      end
      PH_LIST: begin
        fld_cnt++;
        if (fld_cnt >= 3'd2) begin
          fld_cnt = '0;
          ph = PH_TYPE;
        end
      end
      PH_TYPE: begin
        if (b != HostNameType) begin
          r = '{1'b1, 8'h00, 1'b1, ST_MALFORMED};
          blk_finished = 1'b1;
          ph = PH_DONE;
        end else begin
          host_left = '0;
          fld_cnt = '0;
          ph = PH_NLEN;
        end
      end
      PH_NLEN: begin
        host_left = {host_left[7:0], b};
        fld_cnt++;
        if (fld_cnt >= 3'd2) begin
          fld_cnt = '0;
          if (host_left == '0) begin
            r = '{1'b1, 8'h00, 1'b1, ST_EMPTY};
            blk_finished = 1'b1;
            ph = PH_DONE;
          end else begin
            ph = PH_NAME;
          end
        end
      end
      PH_NAME: begin
        host_left--;
        if (host_left == '0) begin
          r = '{1'b1, b, 1'b1, ST_NAME};
          blk_finished = 1'b1;
          ph = PH_DONE;
        end else if (eob) begin
          r = '{1'b1, 8'h00, 1'b1, ST_MALFORMED};
          blk_finished = 1'b1;
          ph = PH_DONE;
        end else begin
          r = '{1'b1, b, 1'b0, ST_NAME};
        end
      end
      default: ;
    endcase
    if (eob) begin
      if (!blk_finished) begin
        r = '{1'b1, 8'h00, 1'b1,
              (ph == PH_TRAIL && ext_seen == {1'b0, ext_len_total}) ? ST_NO_SNI : ST_MALFORMED};
      end
      ph = PH_WAIT;
      blk_finished = 1'b0;
    end
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 60) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void add_ext(input logic [15:0] id, input logic [15:0] len);
    ext_q.push_back(id[15:8]);
    ext_q.push_back(id[7:0]);
    ext_q.push_back(len[15:8]);
    ext_q.push_back(len[7:0]);
    repeat (len) ext_q.push_back(8'($urandom));
  endfunction

  // kinds: SNI message, message without SNI, noise; some get cut short
  task automatic build_block();
    int unsigned kind, npre, cnt, pick, keep;
    logic [15:0] tot, nlen;
    logic [7:0]  bytes_q[$];
    beat_t       bt;
    ext_q.delete();
    blk_q.delete();
    kind = $urandom_range(0, 9);
    npre = ($urandom_range(0, 39) == 0) ? $urandom_range(100, 400) : $urandom_range(0, 3);
    if (kind >= 8) begin
      npre = $urandom_range(0, 20);
      repeat ($urandom_range(1, 16)) bytes_q.push_back(8'($urandom));
    end else begin
      cnt = $urandom_range(0, (kind < 6) ? 3 : 4);
      repeat (cnt) begin
        add_ext(16'($urandom_range(1, 65535)),
                ($urandom_range(0, 4) == 0) ? 16'd0 : 16'($urandom_range(1, 6)));
      end
      if (kind < 6) begin
        ext_q.push_back(SniExtId[15:8]);
        ext_q.push_back(SniExtId[7:0]);
        repeat (4) ext_q.push_back(8'($urandom));
        ext_q.push_back(($urandom_range(0, 7) == 0) ? 8'($urandom_range(1, 255)) : HostNameType);
        pick = $urandom_range(0, 24);
        if (pick < 3) nlen = '0;
        else if (pick == 3) nlen = 16'($urandom_range(100, 300));
        else nlen = 16'($urandom_range(1, 12));
        ext_q.push_back(nlen[15:8]);
        ext_q.push_back(nlen[7:0]);
        repeat (nlen) ext_q.push_back(8'($urandom));
        repeat ($urandom_range(0, 3)) ext_q.push_back(8'($urandom));
      end
      tot = 16'(ext_q.size());
      pick = $urandom_range(0, 5);
      if (pick == 0) tot = 16'($urandom);
      else if (pick == 1) tot = tot + 16'($urandom_range(1, 3));
      else if (pick == 2) repeat ($urandom_range(1, 3)) ext_q.push_back(8'($urandom));
      repeat (npre) bytes_q.push_back(8'($urandom));
      bytes_q.push_back(tot[15:8]);
      bytes_q.push_back(tot[7:0]);
      foreach (ext_q[i]) bytes_q.push_back(ext_q[i]);
      if ($urandom_range(0, 5) == 0) begin
        keep = $urandom_range(1, bytes_q.size());
        while (bytes_q.size() > keep) void'(bytes_q.pop_back());
      end
    end
    foreach (bytes_q[i]) begin
      bt.data = bytes_q[i];
      bt.off = (i == 0) ? 16'(npre) : 16'($urandom);
      bt.eob = (i == bytes_q.size() - 1);
      blk_q.push_back(bt);
    end
  endtask

  task automatic send_beat(input beat_t bt, input result_t want);
    int unsigned gap;
    result_t r;
    gap = steady ? 0 : pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {bt.off, bt.data};
    s_axis_tlast <= bt.eob;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    r = sni_predict(bt.data, bt.off, bt.eob);
    if (want.valid) r = want;
    if (r.valid) result_q.push_back(r);
  endtask

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      m_axis_tready <= 1'b1;
      if (!steady && $urandom_range(0, 2) == 0) stall_left = pick_gap();
    end
  end

  always @(posedge clk_i) begin : check_results
    result_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (result_q.size() == 0) begin
        $error("unexpected beat: name_byte %h name_last %b status %0d",
               m_axis_tdata, m_axis_tlast, m_axis_tuser);
        mismatch_cnt++;
      end else begin
        e = result_q.pop_front();
        if (m_axis_tdata !== e.name_byte) begin
          $error("name_byte: expected %h, got %h", e.name_byte, m_axis_tdata);
          mismatch_cnt++;
        end
        if (m_axis_tlast !== e.name_last) begin
          $error("name_last: expected %b, got %b", e.name_last, m_axis_tlast);
          mismatch_cnt++;
        end
        if (m_axis_tuser !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, m_axis_tuser);
          mismatch_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cnt = 0;
    end else begin
      idle_cnt++;
      if (idle_cnt >= IdleLimit) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    int unsigned sent;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (DirRows[i]) send_beat(DirRows[i].bt, DirRows[i].want);
    sent = 0;
    while (sent < RandBeats) begin
      steady = ($urandom_range(0, 7) == 0);
      build_block();
      foreach (blk_q[i]) send_beat(blk_q[i], NoCheck);
      sent += blk_q.size();
    end
    s_axis_tvalid <= 1'b0;
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: files.f
design/tse_pkg.sv
design/tse_step.sv
design/tls_sni_hostname_extractor.sv
design/tse_checker.sv
tb/tls_sni_hostname_extractor_tb.sv
